FILE: src/nnr_pkg.sv
// Shared types and constants for the nearest-neighbor rotation block.
package nnr_pkg;

  localparam int TRIG_W  = 17;   // Q1.16 sine and cosine
  localparam int SIZE_W  = 10;   // source frame size registers
  localparam int IDX_W   = 10;   // row and column indexes of an item
  localparam int PIX_W   = 8;
  localparam int DEST_W  = 11;
  localparam int COORD_W = 13;   // rounded source coordinate magnitude

  localparam logic [DEST_W-1:0] DEST_LIMIT = 11'd2047;

  typedef enum logic [1:0] {
    CFG_SINE   = 2'd0,
    CFG_COSINE = 2'd1,
    CFG_ROWS   = 2'd2,
    CFG_COLS   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic [TRIG_W-1:0] sine;
    logic [TRIG_W-1:0] cosine;
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } item_t;

  // Word handed from the mapping pipeline to the frame store stage.
  typedef struct packed {
    op_t               op;
    logic              wr_ok;
    logic              hit;
    logic [PIX_W-1:0]  pix;
    logic [DEST_W-1:0] drows;
    logic [DEST_W-1:0] dcols;
  } map_res_t;

endpackage

FILE: src/nnr_map.sv
// Five-stage coordinate mapping pipeline: products, sums, source coordinates, rounding, bounds and address.
module nnr_map #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512,
  parameter int AW       = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nnr_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  nnr_pkg::item_t    in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output nnr_pkg::map_res_t out_info,
  output logic [AW-1:0]     out_addr
);
  import nnr_pkg::*;

  localparam int NST   = 5;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  // round((sum) / 2^16) half up, saturated to the destination size limit
  function automatic logic [DEST_W-1:0] dest_round(input logic [27:0] sum);
    logic [28:0] rnd;
    rnd = 29'(sum) + 29'h8000;
    if (rnd[28:16] > 13'(DEST_LIMIT)) return DEST_LIMIT;
    return rnd[26:16];
  endfunction

  logic [NST-1:0] v_r, v_nxt, en;
  item_t          it_r [NST];

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
    v_nxt = {v_r[NST-2:0], in_valid};
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) if (en[k]) v_r[k] <= v_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) it_r[0] <= in_item;
    for (int k = 1; k < NST; k++) if (en[k]) it_r[k] <= it_r[k-1];
  end

  // stage 1: all first-level products
  logic [33:0] ss_r, sc_r, ss_nxt, sc_nxt;
  logic [26:0] ci_r, sj_r, si_r, cj_r, ci_nxt, sj_nxt, si_nxt, cj_nxt;
  logic [26:0] crw_r, scl_r, ccl_r, srw_r, crw_nxt, scl_nxt, ccl_nxt, srw_nxt;

  always_comb begin
    ss_nxt  = 34'(cfg.sine) * 34'(cfg.sine);
    sc_nxt  = 34'(cfg.sine) * 34'(cfg.cosine);
    ci_nxt  = 27'(cfg.cosine) * 27'(in_item.row);
    sj_nxt  = 27'(cfg.sine) * 27'(in_item.col);
    si_nxt  = 27'(cfg.sine) * 27'(in_item.row);
    cj_nxt  = 27'(cfg.cosine) * 27'(in_item.col);
    crw_nxt = 27'(cfg.cosine) * 27'(cfg.rows);
    scl_nxt = 27'(cfg.sine) * 27'(cfg.cols);
    ccl_nxt = 27'(cfg.cosine) * 27'(cfg.cols);
    srw_nxt = 27'(cfg.sine) * 27'(cfg.rows);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ss_r  <= ss_nxt;
      sc_r  <= sc_nxt;
      ci_r  <= ci_nxt;
      sj_r  <= sj_nxt;
      si_r  <= si_nxt;
      cj_r  <= cj_nxt;
      crw_r <= crw_nxt;
      scl_r <= scl_nxt;
      ccl_r <= ccl_nxt;
      srw_r <= srw_nxt;
    end
  end

  // stage 2: scale by source rows, combine the per-pixel terms
  logic [43:0]        ssr_r, scr_r, ssr_nxt, scr_nxt;
  logic signed [27:0] diff_r, diff_nxt;
  logic [27:0]        sum_r, sum_nxt, rsum_r, rsum_nxt, csum_r, csum_nxt;

  always_comb begin
    ssr_nxt  = 44'(ss_r) * 44'(cfg.rows);
    scr_nxt  = 44'(sc_r) * 44'(cfg.rows);
    diff_nxt = $signed({1'b0, ci_r}) - $signed({1'b0, sj_r});
    sum_nxt  = 28'(si_r) + 28'(cj_r);
    rsum_nxt = 28'(crw_r) + 28'(scl_r);
    csum_nxt = 28'(ccl_r) + 28'(srw_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ssr_r  <= ssr_nxt;
      scr_r  <= scr_nxt;
      diff_r <= diff_nxt;
      sum_r  <= sum_nxt;
      rsum_r <= rsum_nxt;
      csum_r <= csum_nxt;
    end
  end

  // stage 3: Q32 source coordinates and destination size
  logic signed [45:0] rowq_r, colq_r, rowq_nxt, colq_nxt;
  logic [DEST_W-1:0]  drows3_r, dcols3_r, drows3_nxt, dcols3_nxt;

  always_comb begin
    rowq_nxt   = $signed({2'b00, ssr_r}) + $signed({{2{diff_r[27]}}, diff_r, 16'h0000});
    colq_nxt   = $signed({2'b00, sum_r, 16'h0000}) - $signed({2'b00, scr_r});
    drows3_nxt = dest_round(rsum_r);
    dcols3_nxt = dest_round(csum_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rowq_r   <= rowq_nxt;
      colq_r   <= colq_nxt;
      drows3_r <= drows3_nxt;
      dcols3_r <= dcols3_nxt;
    end
  end

  // stage 4: round half up; anything at or below -1/2 is off-frame
  logic signed [45:0] trow, tcol;
  logic [COORD_W-1:0] sr_r, scol_r, sr_nxt, scol_nxt;
  logic               rpos_r, cpos_r, indest_r, rpos_nxt, cpos_nxt, indest_nxt;
  logic [DEST_W-1:0]  drows4_r, dcols4_r;

  always_comb begin
    trow       = rowq_r + 46'sh0000_8000_0000;
    tcol       = colq_r + 46'sh0000_8000_0000;
    rpos_nxt   = !trow[45] && (trow != '0);
    cpos_nxt   = !tcol[45] && (tcol != '0);
    sr_nxt     = trow[44:32];
    scol_nxt   = tcol[44:32];
    indest_nxt = (DEST_W'(it_r[2].row) < drows3_r) && (DEST_W'(it_r[2].col) < dcols3_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sr_r     <= sr_nxt;
      scol_r   <= scol_nxt;
      rpos_r   <= rpos_nxt;
      cpos_r   <= cpos_nxt;
      indest_r <= indest_nxt;
      drows4_r <= drows3_r;
      dcols4_r <= dcols3_r;
    end
  end

  // stage 5: frame bounds and store address
  logic          hit_r, hit_nxt, wrok_r, wrok_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [DEST_W-1:0] drows5_r, dcols5_r;

  always_comb begin
    hit_nxt = indest_r && rpos_r && cpos_r &&
              (sr_r < COORD_W'(cfg.rows)) && (sr_r < COORD_W'(MAX_ROWS)) &&
              (scol_r < COORD_W'(cfg.cols)) && (scol_r < COORD_W'(MAX_COLS));
    wrok_nxt = (COORD_W'(it_r[3].row) < COORD_W'(MAX_ROWS)) &&
               (COORD_W'(it_r[3].col) < COORD_W'(MAX_COLS));
    if (it_r[3].op == OP_QUERY) begin
      addr_nxt = AW'(sr_r) * AW'(MAX_COLS) + AW'(scol_r);
    end else begin
      addr_nxt = AW'(it_r[3].row) * AW'(MAX_COLS) + AW'(it_r[3].col);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hit_r    <= hit_nxt;
      wrok_r   <= wrok_nxt;
      addr_r   <= addr_nxt;
      drows5_r <= drows4_r;
      dcols5_r <= dcols4_r;
    end
  end

  assign out_valid      = v_r[NST-1];
  assign out_addr       = addr_r;
  assign out_info.op    = it_r[NST-1].op;
  assign out_info.wr_ok = wrok_r;
  assign out_info.hit   = hit_r;
  assign out_info.pix   = it_r[NST-1].pix;
  assign out_info.drows = drows5_r;
  assign out_info.dcols = dcols5_r;

  // a stalled last stage keeps its word
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !out_ready |=> v_r[NST-1])
    else $error("last mapping stage lost a stalled word");

  // backpressure reaches the input only when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input stalled with a bubble in the pipeline");

  // a hit always addresses an entry inside the store
  a_hit_addr: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && it_r[NST-1].op == OP_QUERY && hit_r |->
      ({1'b0, addr_r} < (AW+1)'(DEPTH)))
    else $error("hit address outside frame store");

endmodule

FILE: src/nnr_store.sv
// Frame store with one access per cycle while the output is not stalled, and the result output register.
module nnr_store #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512,
  parameter int AW       = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  nnr_pkg::map_res_t             in_info,
  input  logic [AW-1:0]                 in_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nnr_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_hit,
  output logic [nnr_pkg::DEST_W-1:0]    out_drows,
  output logic [nnr_pkg::DEST_W-1:0]    out_dcols
);
  import nnr_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rd_r;
  logic              ov_r, ov_nxt, hit_r;
  logic [DEST_W-1:0] drows_r, dcols_r;
  logic              en;

  assign en       = !ov_r || out_ready;
  assign in_ready = en;
  assign ov_nxt   = in_valid && (in_info.op == OP_QUERY);

  // loads write here, in stream order with the reads of earlier queries
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      if (in_info.op == OP_LOAD && in_info.wr_ok) mem[in_addr] <= in_info.pix;
      if (in_info.op == OP_QUERY && in_info.hit) rd_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      hit_r   <= in_info.hit;
      drows_r <= in_info.drows;
      dcols_r <= in_info.dcols;
    end
  end

  assign out_valid = ov_r;
  assign out_hit   = hit_r;
  assign out_pixel = hit_r ? rd_r : '0;
  assign out_drows = drows_r;
  assign out_dcols = dcols_r;

endmodule

FILE: src/nearest_neighbor_image_rotation.sv
// Top level of the nearest-neighbor frame rotation block.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tuser: operation; tdata: row, col, pixel
//  out_    | master    | out_tvalid/out_tready| tuser: source_hit; tdata: pixel, sizes
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One word per clock in while the output is not stalled; only queries give a result
// word, after the five mapping stages and the frame store read register.
// Loads take the same path and write the store in that last stage, so reads and
// writes stay in stream order through a single store port.
// Reset clears valid bits and loads the default angle (sine 0, cosine 1.0) and a
// 512 x 512 frame size; the frame store itself is not cleared.
// A stall on out_tready holds the occupied stages; bubbles still close up, so the
// input keeps accepting words until every stage is full.
module nearest_neighbor_image_rotation #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [9:0] row_index, [19:10] col_index, [27:20] pixel_in
  input  logic [0:0]  in_tuser,   // [0] operation
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] pixel_out, [18:8] dest_rows, [29:19] dest_cols
  output logic [0:0]  out_tuser,  // [0] source_hit
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import nnr_pkg::*;

  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

  // configuration registers; the user must write them only while no word is in flight (not enforced here)
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sine   <= '0;
      cfg_r.cosine <= 17'h10000;
      cfg_r.rows   <= 10'd512;
      cfg_r.cols   <= 10'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SINE:   cfg_r.sine   <= cfg_data;
        CFG_COSINE: cfg_r.cosine <= cfg_data;
        CFG_ROWS:   cfg_r.rows   <= cfg_data[SIZE_W-1:0];
        CFG_COLS:   cfg_r.cols   <= cfg_data[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  // unpack the input word
  item_t in_item;
  assign in_item.op  = op_t'(in_tuser[0]);
  assign in_item.row = in_tdata[9:0];
  assign in_item.col = in_tdata[19:10];
  assign in_item.pix = in_tdata[27:20];

  logic          map_valid, map_ready;
  map_res_t      map_info;
  logic [AW-1:0] map_addr;

  nnr_map #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .AW      (AW)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_valid(map_valid),
    .out_ready(map_ready),
    .out_info (map_info),
    .out_addr (map_addr)
  );

  logic [PIX_W-1:0]  res_pixel;
  logic              res_hit;
  logic [DEST_W-1:0] res_drows, res_dcols;

  nnr_store #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .AW      (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (map_valid),
    .in_ready (map_ready),
    .in_info  (map_info),
    .in_addr  (map_addr),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_pixel(res_pixel),
    .out_hit  (res_hit),
    .out_drows(res_drows),
    .out_dcols(res_dcols)
  );

  // pack the result word, zero fill to the byte boundary
  assign out_tdata = {2'b00, res_dcols, res_drows, res_pixel};
  assign out_tuser = res_hit;

endmodule
